### hw/rtl/tlif_pkg.sv
package tlif_pkg;

  localparam int LINE_COUNT_BITS = 16;
  localparam int CFG_ADDR_BITS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_DEL  = 8'h7F;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_SP   = 8'h20;
  localparam logic [7:0] B_TAB  = 8'h09;

  typedef enum logic [2:0] {
    K_LINE_BYTE = 3'd0,
    K_DELETE    = 3'd1,
    K_LINE_END  = 3'd2,
    K_OOB_BYTE  = 3'd3,
    K_OOB_END   = 3'd4,
    K_CLOSE     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_IAC    = 2'd1,
    PH_OPTION = 2'd2,
    PH_SUB    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_BINARY_MODE    = 2'd0,
    REG_BACKSPACE_EN   = 2'd1,
    REG_MAX_LINE_BYTES = 2'd2
  } reg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

### hw/rtl/tlif_in_if.sv
interface tlif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink (input valid, input rx_byte, input chunk_last, output ready);
endinterface

### hw/rtl/tlif_out_if.sv
interface tlif_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

### hw/rtl/telnet_line_input_filter_top.sv
// Telnet line-input filter. Each received word is processed in the cycle it is
// accepted; its zero, one or two results go into a four-entry output queue, and
// one result word leaves per cycle while out_if.ready is high. A new input word
// is taken every cycle while the queue has room for two results, so with the
// output unstalled the sustained rate is one input word per cycle when each word
// yields at most one result; else the one-result-per-cycle output port bounds it.
// Registers must be written through the APB port only while idle; not enforced.
module telnet_line_input_filter_top
  import tlif_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  tlif_in_if.sink                  in_if,
  tlif_out_if.source               out_if,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [LINE_COUNT_BITS-1:0] COUNT_MAX = {LINE_COUNT_BITS{1'b1}};

  logic        binary_mode_r;
  logic        backspace_en_r;
  logic [15:0] max_line_bytes_r;

  logic                       prev_cr_r, prev_cr_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [LINE_COUNT_BITS-1:0] line_count_r, line_count_nxt;
  logic                       oob_r, oob_nxt;
  logic                       chunk_start_r, chunk_start_nxt;
  logic                       closed_r, closed_nxt;

  res_t                    queue_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_BITS:0]   fill_r;

  res_t       slot [2];
  logic [1:0] n_res;
  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       endc;
  reg_idx_t   widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r    <= 1'b0;
      backspace_en_r   <= 1'b0;
      max_line_bytes_r <= 16'd4096;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_BINARY_MODE:    binary_mode_r    <= pwdata[0];
        REG_BACKSPACE_EN:   backspace_en_r   <= pwdata[0];
        REG_MAX_LINE_BYTES: max_line_bytes_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_BINARY_MODE:    prdata = {31'd0, binary_mode_r};
      REG_BACKSPACE_EN:   prdata = {31'd0, backspace_en_r};
      REG_MAX_LINE_BYTES: prdata = {16'd0, max_line_bytes_r};
      default:            prdata = 32'd0;
    endcase
  end

  assign in_if.ready = (fill_r <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;
  assign c           = in_if.rx_byte;
  assign endc        = in_if.chunk_last;

  always_comb begin
    prev_cr_nxt     = prev_cr_r;
    phase_nxt       = phase_r;
    line_count_nxt  = line_count_r;
    oob_nxt         = oob_r;
    chunk_start_nxt = chunk_start_r;
    closed_nxt      = closed_r;
    n_res           = 2'd0;
    slot[0]         = '{kind: K_LINE_BYTE, value: 8'd0, last: 1'b0};
    slot[1]         = '{kind: K_LINE_BYTE, value: 8'd0, last: 1'b0};
    if (!closed_r) begin
      if (chunk_start_r && (33'(line_count_r) >= 33'(max_line_bytes_r))) begin
        closed_nxt = 1'b1;
        slot[0]    = '{kind: K_CLOSE, value: 8'd0, last: 1'b0};
        n_res      = 2'd1;
      end else begin
        chunk_start_nxt = endc;
        if (binary_mode_r) begin
          slot[0]     = '{kind: K_LINE_BYTE, value: c, last: 1'b0};
          n_res       = 2'd1;
          prev_cr_nxt = 1'b0;
          if (line_count_r != COUNT_MAX) begin
            line_count_nxt = line_count_r + 1'b1;
          end
          if (endc) begin
            slot[1]        = '{kind: K_LINE_END, value: 8'd0, last: 1'b0};
            n_res          = 2'd2;
            line_count_nxt = '0;
          end
        end else begin
          case (phase_r)
            PH_IDLE: begin
              if ((c >= 8'h21 && c <= 8'h7E) || c == B_SP || c == B_TAB) begin
                slot[0] = '{kind: K_LINE_BYTE, value: c, last: 1'b0};
                n_res   = 2'd1;
                if (line_count_r != COUNT_MAX) begin
                  line_count_nxt = line_count_r + 1'b1;
                end
              end else if (backspace_en_r && (c == B_BS || c == B_DEL)) begin
                if (line_count_r != '0) begin
                  slot[0]        = '{kind: K_DELETE, value: 8'd0, last: 1'b0};
                  n_res          = 2'd1;
                  line_count_nxt = line_count_r - 1'b1;
                end
              end else if (c == B_IAC) begin
                slot[0]   = '{kind: K_OOB_BYTE, value: c, last: 1'b0};
                n_res     = 2'd1;
                oob_nxt   = 1'b1;
                phase_nxt = PH_IAC;
              end
              if (c == B_CR || (c == B_LF && !prev_cr_r)) begin
                slot[n_res[0]] = '{kind: K_LINE_END, value: 8'd0, last: 1'b0};
                n_res          = n_res + 2'd1;
                line_count_nxt = '0;
              end
              prev_cr_nxt = (c == B_CR);
            end
            PH_IAC: begin
              slot[0] = '{kind: K_OOB_BYTE, value: c, last: 1'b0};
              n_res   = 2'd1;
              oob_nxt = 1'b1;
              if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
                phase_nxt = PH_OPTION;
              end else if (c == B_SE) begin
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_SUB;
              end
            end
            PH_OPTION: begin
              slot[0]   = '{kind: K_OOB_BYTE, value: c, last: 1'b0};
              n_res     = 2'd1;
              oob_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end
            default: begin
              slot[0] = '{kind: K_OOB_BYTE, value: c, last: 1'b0};
              n_res   = 2'd1;
              oob_nxt = 1'b1;
              if (c == B_SE) begin
                phase_nxt = PH_IDLE;
              end
            end
          endcase
          if (endc && oob_nxt) begin
            slot[n_res[0]] = '{kind: K_OOB_END, value: 8'd0, last: 1'b0};
            n_res          = n_res + 2'd1;
            oob_nxt        = 1'b0;
          end
        end
      end
    end
    if (n_res == 2'd1) begin
      slot[0].last = 1'b1;
    end else if (n_res == 2'd2) begin
      slot[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cr_r     <= 1'b0;
      phase_r       <= PH_IDLE;
      line_count_r  <= '0;
      oob_r         <= 1'b0;
      chunk_start_r <= 1'b1;
      closed_r      <= 1'b0;
    end else if (in_acc) begin
      prev_cr_r     <= prev_cr_nxt;
      phase_r       <= phase_nxt;
      line_count_r  <= line_count_nxt;
      oob_r         <= oob_nxt;
      chunk_start_r <= chunk_start_nxt;
      closed_r      <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      queue_r[wr_ptr_r] <= slot[0];
      if (n_res == 2'd2) begin
        queue_r[wr_ptr_r + 1'b1] <= slot[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_BITS'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + (in_acc ? (QUEUE_PTR_BITS+1)'(n_res) : '0)
                       - (out_acc ? (QUEUE_PTR_BITS+1)'(1) : '0);
    end
  end

  assign out_if.valid = (fill_r != '0);
  assign out_if.kind  = queue_r[rd_ptr_r].kind;
  assign out_if.value = queue_r[rd_ptr_r].value;
  assign out_if.last  = queue_r[rd_ptr_r].last;

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlif_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_LINE_BYTES = 40;

  class filter_scoreboard;
    logic                       binary_on;
    logic                       erase_on;
    logic [15:0]                line_limit;
    logic                       after_cr;
    phase_t                     phase;
    logic [LINE_COUNT_BITS-1:0] line_len;
    logic                       oob_open;
    logic                       chunk_start;
    logic                       shut;
    res_t                       expected_words[$];
    res_t                       step_words[$];
    int                         failures;

    function new();
      binary_on = 1'b0;
      erase_on = 1'b0;
      line_limit = 16'd4096;
      after_cr = 1'b0;
      phase = PH_IDLE;
      line_len = '0;
      oob_open = 1'b0;
      chunk_start = 1'b1;
      shut = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_BINARY_MODE: binary_on = val[0];
        REG_BACKSPACE_EN: erase_on = val[0];
        REG_MAX_LINE_BYTES: line_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function void emit(kind_t k, logic [7:0] v);
      res_t w;
      w.kind = k;
      w.value = v;
      w.last = 1'b0;
      step_words.push_back(w);
    endfunction

    function void add_line_byte(logic [7:0] c);
      emit(K_LINE_BYTE, c);
      if (line_len != '1) line_len++;
    endfunction

    function void add_oob_byte(logic [7:0] c);
      emit(K_OOB_BYTE, c);
      oob_open = 1'b1;
    endfunction

    function void take_byte(logic [7:0] c, logic endc);
      res_t w;
      if (shut) return;
      step_words = {};
      if (chunk_start && line_len >= line_limit) begin
        shut = 1'b1;
        emit(K_CLOSE, 8'h00);
      end else begin
        if (binary_on) begin
          add_line_byte(c);
          after_cr = 1'b0;
          if (endc) begin
            emit(K_LINE_END, 8'h00);
            line_len = '0;
          end
        end else begin
          case (phase)
            PH_IDLE: begin
              if ((c >= 8'h21 && c <= 8'h7E) || c == B_SP || c == B_TAB) begin
                add_line_byte(c);
              end else if (erase_on && (c == B_BS || c == B_DEL)) begin
                if (line_len != '0) begin
                  emit(K_DELETE, 8'h00);
                  line_len--;
                end
              end else if (c == B_IAC) begin
                add_oob_byte(c);
                phase = PH_IAC;
              end
              if (c == B_CR || (c == B_LF && !after_cr)) begin
                emit(K_LINE_END, 8'h00);
                line_len = '0;
              end
              after_cr = (c == B_CR);
            end
            PH_IAC: begin
              add_oob_byte(c);
              if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
                phase = PH_OPTION;
              end else if (c == B_SE) begin
                phase = PH_IDLE;
              end else begin
                phase = PH_SUB;
              end
            end
            PH_OPTION: begin
              add_oob_byte(c);
              phase = PH_IDLE;
            end
            default: begin
              add_oob_byte(c);
              if (c == B_SE) phase = PH_IDLE;
            end
          endcase
          if (endc && oob_open) begin
            emit(K_OOB_END, 8'h00);
            oob_open = 1'b0;
          end
        end
        chunk_start = endc;
      end
      if (step_words.size() > 0) begin
        w = step_words.pop_back();
        w.last = 1'b1;
        step_words.push_back(w);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void match_word(logic [2:0] k, logic [7:0] v, logic l);
      res_t want;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected word: kind %0d value %02h last %0b", k, v, l);
        return;
      end
      want = expected_words.pop_front();
      if (want.kind !== k || want.value !== v || want.last !== l) begin
        failures++;
        if (failures <= 10)
          $display("Mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                   want.kind, want.value, want.last, k, v, l);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  bit                       no_idle = 1'b0;
  int unsigned              cycles = 0;
  filter_scoreboard         sb;

  tlif_in_if  rx_if ();
  tlif_out_if tx_if ();

  telnet_line_input_filter_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (rx_if),
    .out_if  (tx_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    tx_if.ready <= no_idle || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && tx_if.valid && tx_if.ready)
      sb.match_word(tx_if.kind, tx_if.value, tx_if.last);
  end

  task automatic send_word(input logic [7:0] b, input logic endc);
    while (!no_idle && $urandom_range(99) < 25) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.chunk_last <= endc;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    sb.take_byte(b, endc);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Ends any telnet sequence, then the line and the chunk.
  task automatic finish_line();
    send_word(B_SE, 1'b0);
    send_word(B_CR, 1'b1);
  endtask

  task automatic send_text_stream(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned extra;
    logic [7:0]  seq[$];
    sent = 0;
    while (sent < n) begin
      seq = {};
      pick = $urandom_range(99);
      if (pick < 50) begin
        seq.push_back(8'($urandom_range(8'h7E, 8'h21)));
      end else if (pick < 55) begin
        seq.push_back($urandom_range(1) ? B_SP : B_TAB);
      end else if (pick < 62) begin
        seq.push_back(B_CR);
        if ($urandom_range(1)) seq.push_back(B_LF);
      end else if (pick < 65) begin
        seq.push_back(B_LF);
      end else if (pick < 71) begin
        seq.push_back($urandom_range(1) ? B_BS : B_DEL);
      end else if (pick < 80) begin
        seq = {B_IAC, 8'($urandom_range(B_DONT, B_WILL)), 8'($urandom())};
      end else if (pick < 83) begin
        seq = {B_IAC, B_SE};
      end else if (pick < 91) begin
        seq.push_back(B_IAC);
        seq.push_back($urandom_range(1) ? 8'($urandom_range(250, 241)) : 8'($urandom()));
        extra = $urandom_range(4);
        repeat (extra) seq.push_back(8'($urandom()));
        seq.push_back(B_IAC);
        seq.push_back(B_SE);
      end else begin
        seq.push_back(8'($urandom()));
      end
      foreach (seq[i]) begin
        send_word(seq[i], $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  task automatic send_binary_stream(input int unsigned n);
    repeat (n) send_word(8'($urandom()), $urandom_range(5) == 0);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    rx_if.chunk_last = 1'b0;
    tx_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h41, 1'b0);
    send_word(8'h21, 1'b0);
    send_word(8'h7E, 1'b0);
    send_word(B_SP, 1'b0);
    send_word(B_TAB, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(B_DEL, 1'b0);
    send_word(B_BS, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(B_CR, 1'b0);
    send_word(B_LF, 1'b0);
    send_word(B_LF, 1'b1);
    send_word(B_IAC, 1'b0);
    send_word(B_WILL, 1'b0);
    send_word(8'h01, 1'b1);
    send_word(B_IAC, 1'b0);
    send_word(B_SE, 1'b0);
    send_word(B_IAC, 1'b0);
    send_word(8'hFA, 1'b0);
    send_word(8'h18, 1'b1);
    send_word(B_IAC, 1'b0);
    send_word(B_SE, 1'b1);

    wait_for_results();
    write_reg(REG_BACKSPACE_EN, 32'd1);
    send_word(B_BS, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(B_DEL, 1'b0);
    send_word(B_DEL, 1'b0);
    send_word(B_CR, 1'b1);

    wait_for_results();
    write_reg(REG_MAX_LINE_BYTES, 32'd65535);
    no_idle = 1'b1;
    send_text_stream(250);
    finish_line();
    no_idle = 1'b0;

    // The telnet phase must survive a stretch in binary mode.
    send_word(B_IAC, 1'b0);
    wait_for_results();
    write_reg(REG_BINARY_MODE, 32'd1);
    write_reg(REG_MAX_LINE_BYTES, 32'd1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_binary_stream(200);
    send_word(8'h55, 1'b1);
    wait_for_results();
    write_reg(REG_BINARY_MODE, 32'd0);
    send_word(B_WILL, 1'b0);
    send_word(8'h03, 1'b1);

    repeat (4) begin
      wait_for_results();
      write_reg(REG_BINARY_MODE, 32'($urandom_range(3) == 0));
      write_reg(REG_BACKSPACE_EN, $urandom_range(1));
      write_reg(REG_MAX_LINE_BYTES, $urandom_range(65535, 100));
      if (sb.binary_on) begin
        send_binary_stream(180);
      end else begin
        send_text_stream(180);
      end
      finish_line();
    end

    // A line that holds the limit when a chunk starts closes the stream.
    wait_for_results();
    write_reg(REG_BINARY_MODE, 32'd0);
    write_reg(REG_MAX_LINE_BYTES, 32'd65535);
    repeat (LONG_LINE_BYTES) send_word(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
    wait_for_results();
    write_reg(REG_MAX_LINE_BYTES, 32'd0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b1);
    wait_for_results();
    write_reg(REG_MAX_LINE_BYTES, 32'(LONG_LINE_BYTES + 2));
    send_word(8'h64, 1'b0);
    repeat (8) send_word(8'($urandom()), 1'($urandom_range(1)));

    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
